// File: hdl/binary_gcd_64_unit_macros.svh
// Assertion macros shared by the binary GCD unit.
// No dependencies; each file that asserts includes this header.
`ifndef BINARY_GCD_64_UNIT_MACROS_SVH
`define BINARY_GCD_64_UNIT_MACROS_SVH

// Check a property on clk_i, masked while rst_ni is low.
`define BGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on clk_i at every edge, reset included.
`define BGCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/bgcd_pkg.sv
// Package for the binary GCD unit: widths, trailing-zero helper, and the
// command/status structs between controller and datapath. No dependencies.
package bgcd_pkg;

  localparam int BGCD_OPERAND_WIDTH = 64;

  // Bits examined per strip step; a step shifts by at most this many.
  localparam int CHUNK    = 8;
  localparam int CHUNK_CW = $clog2(CHUNK + 1);

  typedef struct packed {
    logic load;
    logic shift_common;
    logic strip_both;
    logic strip_a;
    logic subtract;
    logic finish;
  } bgcd_cmd_t;

  typedef struct packed {
    logic any_zero;
    logic common_even;
    logic a_odd;
    logic b_odd;
    logic equal;
  } bgcd_status_t;

  // Trailing zeros of the low chunk; CHUNK when the chunk is all zero.
  function automatic logic [CHUNK_CW-1:0] ctz_chunk(input logic [CHUNK-1:0] x);
    logic [CHUNK_CW-1:0] n;
    logic                found;
    n     = CHUNK_CW'(CHUNK);
    found = 1'b0;
    for (int i = 0; i < CHUNK; i++) begin
      if (x[i] && !found) begin
        n     = CHUNK_CW'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/bgcd_ctrl.sv
// Sequencer for the binary GCD unit: walks setup, stripping and reduction.
// Depends on bgcd_pkg and binary_gcd_64_unit_macros.svh.
`include "binary_gcd_64_unit_macros.svh"

module bgcd_ctrl
  import bgcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  output logic         done_o,
  input  bgcd_status_t status_i,
  output bgcd_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COMMON = 3'd1;
  localparam logic [2:0] S_ODD    = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_COMMON;
        end
      end
      S_COMMON: begin
        if (status_i.any_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.common_even) begin
          cmd_o.shift_common = 1'b1;
        end else begin
          state_d = S_ODD;
        end
      end
      S_ODD: begin
        if (status_i.a_odd && status_i.b_odd) begin
          state_d = S_REDUCE;
        end else begin
          cmd_o.strip_both = 1'b1;
        end
      end
      S_REDUCE: begin
        if (!status_i.a_odd) begin
          cmd_o.strip_a = 1'b1;
        end else if (status_i.equal) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.subtract = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_d = cmd_o.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  `BGCD_ASSERT(a_done_single, done_q |=> !done_q, "result strobe held longer than one cycle")
  `BGCD_ASSERT(a_start_leaves_idle, (start && !busy) |=> (state_q == S_COMMON), "missed start")
  `BGCD_ASSERT(a_reduce_b_odd, (state_q == S_REDUCE) |-> status_i.b_odd, "b lost odd form")

endmodule

// File: hdl/bgcd_dp.sv
// Datapath for the binary GCD unit: operand registers, shift count,
// subtractor and result register. Depends on bgcd_pkg and the macro header.
`include "binary_gcd_64_unit_macros.svh"

module bgcd_dp
  import bgcd_pkg::*;
#(
  parameter int OPERAND_WIDTH = BGCD_OPERAND_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bgcd_cmd_t                cmd_i,
  output bgcd_status_t             status_o,
  input  logic [OPERAND_WIDTH-1:0] first_operand_i,
  input  logic [OPERAND_WIDTH-1:0] second_operand_i,
  output logic [OPERAND_WIDTH-1:0] divisor_o
);

  localparam int KW = $clog2(OPERAND_WIDTH);

  logic [OPERAND_WIDTH-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic [KW-1:0]            k_q, k_d;
  logic [KW+CHUNK_CW-1:0]   k_sum;
  logic [CHUNK_CW-1:0]      t_common, t_a, t_b;
  logic [OPERAND_WIDTH-1:0] a_or_b;
  logic                     a_lt_b;

  assign a_or_b   = a_q | b_q;
  assign t_common = ctz_chunk(a_or_b[CHUNK-1:0]);
  assign t_a      = ctz_chunk(a_q[CHUNK-1:0]);
  assign t_b      = ctz_chunk(b_q[CHUNK-1:0]);
  assign a_lt_b   = (a_q < b_q);
  assign k_sum    = (KW+CHUNK_CW)'(k_q) + (KW+CHUNK_CW)'(t_common);

  assign status_o.any_zero    = (a_q == '0) || (b_q == '0);
  assign status_o.common_even = !a_or_b[0];
  assign status_o.a_odd       = a_q[0];
  assign status_o.b_odd       = b_q[0];
  assign status_o.equal       = (a_q == b_q);

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    k_d   = k_q;
    res_d = res_q;
    if (cmd_i.load) begin
      a_d = first_operand_i;
      b_d = second_operand_i;
      k_d = '0;
    end
    if (cmd_i.shift_common) begin
      // drop the shared factors of two, counting them
      a_d = a_q >> t_common;
      b_d = b_q >> t_common;
      k_d = k_sum[KW-1:0];
    end
    if (cmd_i.strip_both) begin
      a_d = a_q >> t_a;
      b_d = b_q >> t_b;
    end
    if (cmd_i.strip_a) begin
      a_d = a_q >> t_a;
    end
    if (cmd_i.subtract) begin
      // keep the smaller in b, the difference in a
      a_d = a_lt_b ? (b_q - a_q) : (a_q - b_q);
      b_d = a_lt_b ? a_q : b_q;
    end
    if (cmd_i.finish) begin
      res_d = status_o.any_zero ? a_or_b : (a_q << k_q);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign divisor_o = res_q;

  `BGCD_ASSERT(a_diff_even, cmd_i.subtract |=> (!a_q[0] && b_q[0] && (a_q != '0)), "bad diff")

endmodule

// File: hdl/binary_gcd_64_unit.sv
// Top level of the binary GCD unit: joins the sequencer and the datapath.
// Depends on bgcd_pkg, bgcd_ctrl and bgcd_dp.
//
// Greatest common divisor of two unsigned OPERAND_WIDTH-bit words by the
// binary (Stein) method. Raise start while busy is low to hand over a word
// pair; the unit raises busy on the next cycle and holds it until the result
// is ready. The result appears on divisor_o with done_o high for exactly one
// cycle and must be captured then: the unit does not wait for the receiver.
// A new word may be started in the same cycle that done_o is high, since the
// result sits in its own register. If either operand is zero the result is
// the other one (zero for a pair of zeros): the state after start sees the
// zero and finishes at once, and done_o is registered from that finish.
// Otherwise the time is data dependent and set by the subtract-and-strip
// loop: shared trailing zeros are stripped in groups of up to eight, then the
// remaining trailing zeros of the operand with more of them (both strip
// together), then each subtraction is followed by stripping the trailing
// zeros of the difference in groups of up to eight, and a last step applies
// the shared power of two; done_o is registered from that step. The product
// of the pair at least halves with every subtraction, so no pair needs more
// than 2*OPERAND_WIDTH subtractions.
// Reset is asynchronous and active low; the unit holds no state between words.

module binary_gcd_64_unit
  import bgcd_pkg::*;
#(
  parameter int OPERAND_WIDTH = BGCD_OPERAND_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] first_operand_i,
  input  logic [OPERAND_WIDTH-1:0] second_operand_i,
  output logic [OPERAND_WIDTH-1:0] divisor_o,
  output logic                     done_o
);

  bgcd_cmd_t    cmd;
  bgcd_status_t status;

  // Sequencer: setup, strip, reduce, finish.
  bgcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: operands, shared shift count and result register.
  bgcd_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .divisor_o        (divisor_o)
  );

endmodule

// File: dv/binary_gcd_64_checker.sv
// Result checker for the binary GCD unit: predicts each divisor, matches it in order.
// Depends on bgcd_pkg for the operand width.
module binary_gcd_64_checker
  import bgcd_pkg::*;
#(
  parameter int OPERAND_WIDTH = BGCD_OPERAND_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [OPERAND_WIDTH-1:0] first_operand_i,
  input  logic [OPERAND_WIDTH-1:0] second_operand_i,
  input  logic [OPERAND_WIDTH-1:0] divisor_i,
  input  logic                     done_i,
  output int                       mismatch_count_o,
  output int                       pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OPERAND_WIDTH-1:0] first;
    logic [OPERAND_WIDTH-1:0] second;
    logic [OPERAND_WIDTH-1:0] divisor;
  } gcd_job_t;

  gcd_job_t gcd_jobs_q[$];
  int       mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Stein's method: pull out the shared power of two, keep one operand odd,
  // then subtract the smaller from the larger until the difference vanishes.
  function automatic logic [OPERAND_WIDTH-1:0] stein_divisor(
    input logic [OPERAND_WIDTH-1:0] a,
    input logic [OPERAND_WIDTH-1:0] b
  );
    logic [OPERAND_WIDTH-1:0] x;
    logic [OPERAND_WIDTH-1:0] y;
    logic [OPERAND_WIDTH-1:0] t;
    int                       twos;
    x    = a;
    y    = b;
    twos = 0;
    if (x == '0) return y;
    if (y == '0) return x;
    while (!x[0] && !y[0]) begin
      x >>= 1;
      y >>= 1;
      twos++;
    end
    while (!x[0]) x >>= 1;
    do begin
      while (!y[0]) y >>= 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end while (y != '0);
    return x << twos;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Retire the oldest job on done before queuing a new word: a word may be
  // taken in the very cycle a result leaves.
  always @(posedge clk_i or negedge rst_ni) begin
    gcd_job_t oldest;
    if (!rst_ni) begin
      gcd_jobs_q.delete();
      pending_count_o <= 0;
    end else begin
      if (done_i) begin
        if (gcd_jobs_q.size() == 0) begin
          report_mismatch($sformatf("divisor %h with no word outstanding", divisor_i));
        end else begin
          oldest = gcd_jobs_q.pop_front();
          if (divisor_i !== oldest.divisor)
            report_mismatch($sformatf("gcd(%h, %h): divisor %h, predicted %h",
                                      oldest.first, oldest.second, divisor_i,
                                      oldest.divisor));
        end
      end
      if (start_i && !busy_i) begin
        oldest.first   = first_operand_i;
        oldest.second  = second_operand_i;
        oldest.divisor = stein_divisor(first_operand_i, second_operand_i);
        gcd_jobs_q.push_back(oldest);
      end
      pending_count_o <= gcd_jobs_q.size();
    end
  end

endmodule

// File: dv/tb_binary_gcd_64_unit.sv
// Testbench top for the binary GCD unit: drives operand words, gives the verdict.
// Depends on bgcd_pkg, binary_gcd_64_unit and binary_gcd_64_checker.
module tb_binary_gcd_64_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bgcd_pkg::*;

  localparam int          W            = BGCD_OPERAND_WIDTH;
  localparam int          RANDOM_WORDS = 1530;
  // Margin after the last word drains; allow plenty.
  localparam int          DRAIN_CYCLES = 300;
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          N_DIRECTED   = 23;
  localparam logic [W-1:0] ALL_ONES    = '1;

  logic         clk   = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] first_operand  = '0;
  logic [W-1:0] second_operand = '0;
  logic [W-1:0] divisor;
  logic         done;
  int           mismatch_count;
  int           pending_count;
  int           cycle_count = 0;

  // Zero operands, all ones, lone top bit, large coprime Fibonacci neighbors,
  // big shared power of two, both operand orders, equal values.
  logic [W-1:0] directed_first [N_DIRECTED] = '{
    64'h0, 64'h0, 64'hfedc_ba98_7654_3210, ALL_ONES, 64'h0,
    ALL_ONES, ALL_ONES, 64'h1, 64'h1, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, ALL_ONES, ALL_ONES - 1,
    64'd12200160415121876738, 64'd7540113804746346429, 64'h0000_0300_0000_0000,
    64'd48, 64'd18, 64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0001,
    64'h2, 64'hffff_ffff_0000_0000
  };
  logic [W-1:0] directed_second [N_DIRECTED] = '{
    64'h0, 64'h1234_5678_9abc_def0, 64'h0, 64'h0, ALL_ONES,
    ALL_ONES, 64'h1, ALL_ONES, 64'h1, 64'h8000_0000_0000_0000,
    64'h4000_0000_0000_0000, 64'h3, ALL_ONES - 1, ALL_ONES,
    64'd7540113804746346429, 64'd12200160415121876738, 64'h0000_0000_0090_0000,
    64'd18, 64'd48, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001,
    64'h4000_0000_0000_0000, 64'h0000_0000_ffff_ffff
  };

  binary_gcd_64_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .first_operand_i  (first_operand),
    .second_operand_i (second_operand),
    .divisor_o        (divisor),
    .done_o           (done)
  );

  binary_gcd_64_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .first_operand_i  (first_operand),
    .second_operand_i (second_operand),
    .divisor_i        (divisor),
    .done_i           (done),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the unit hangs or handshakes stop.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 150);
  endfunction

  // Hold start low for the gap, present the word, then wait for the edge
  // that takes it. Return at that edge so the caller can drive the next
  // word (or drop start) in the same step without a second assignment.
  task automatic issue_word(input logic [W-1:0] a, input logic [W-1:0] b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    first_operand  <= a;
    second_operand <= b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every outstanding divisor has come back.
  // Step one edge first so the checker's count reflects the last word taken.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] g;
    int           gbits;
    int           gap;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      issue_word(directed_first[i], directed_second[i], pick_gap());
    wait_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = rand_word();
          b = rand_word();
        end
        4, 5: begin
          // Shared odd factor that fits without overflow.
          gbits = $urandom_range(1, 40);
          g     = (rand_word() >> (W - gbits)) | 1'b1;
          a     = g * (rand_word() >> gbits);
          b     = g * (rand_word() >> gbits);
        end
        6: begin
          a = rand_word() << $urandom_range(0, W - 1);
          b = rand_word() << $urandom_range(0, W - 1);
        end
        7: begin
          a = $urandom_range(0, 3) == 0 ? '0 : rand_word();
          b = '0;
          if ($urandom_range(0, 1)) begin
            b = a;
            a = '0;
          end
        end
        8: begin
          a = rand_word() >> $urandom_range(0, W - 1);
          b = a;
        end
        default: begin
          a = W'($urandom_range(0, 1023));
          b = W'($urandom_range(0, 1023));
        end
      endcase
      // Keep the first 30 words of every hundred free of any idling.
      gap = (i % 100 < 30) ? 0 : pick_gap();
      issue_word(a, b, gap);
      if (i % 250 == 249) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
